### design/scnfu_pkg.sv
// Shared types and constants of the sector cache NFU replacement controller.
// No dependencies; every other design file imports this package.
package scnfu_pkg;

    localparam int SLOTS   = 32;
    localparam int COUNT_W = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int TAG_W   = 32;
    localparam int CTR_W   = 24;
    localparam int LIM_W   = 16;
    localparam int MUL_W   = 8;
    localparam int SLOT_W  = 5;
    localparam int START_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = $clog2(CTR_W);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Operation codes of the input transaction
    typedef enum logic [1:0] {
        OP_ACCESS    = 2'd0,
        OP_SET_DIRTY = 2'd1,
        OP_QUERY     = 2'd2,
        OP_FLUSH     = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MULT    = 1'b1;

    // Result kinds
    localparam logic KIND_WRITEBACK = 1'b0;
    localparam logic KIND_FINAL     = 1'b1;

    // Contents of one cache slot
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic               used;
        logic               dirty;
        logic               accessed;
        logic [COUNT_W-1:0] cnt;
    } t_slot;

    // Update applied by a cell to the slot it takes in
    typedef struct packed {
        logic             clr_dirty;
        logic             wr_dirty;
        logic             dirty_val;
        logic             decay;
        logic             bump;
        logic             set_acc;
        logic             install;
        logic [TAG_W-1:0] tag;
    } t_cell_cmd;

    // One result transaction
    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  sector;
        logic              hit;
        logic              dirty_flag;
        logic              used_flag;
        logic              last;
    } t_result;

endpackage

### design/scnfu_if.sv
// Valid/ready channel interfaces: input, result and configuration write.
// Depends on scnfu_pkg for field widths.
interface scnfu_in_if
    import scnfu_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [TAG_W-1:0]   sector_id;
    logic               dirty_value;
    logic [START_W-1:0] start_slot;

    modport source (output valid, op, sector_id, dirty_value, start_slot, input ready);
    modport sink   (input valid, op, sector_id, dirty_value, start_slot, output ready);
endinterface

interface scnfu_out_if
    import scnfu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  sector;
    logic              hit;
    logic              dirty_flag;
    logic              used_flag;
    logic              last;

    modport source (output valid, kind, slot, sector, hit, dirty_flag, used_flag, last,
                    input ready);
    modport sink   (input valid, kind, slot, sector, hit, dirty_flag, used_flag, last,
                    output ready);
endinterface

interface scnfu_cfg_if
    import scnfu_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/scnfu_cell.sv
// One slot cell of the rotating slot ring: holds a slot and takes its neighbor's.
// Depends on scnfu_pkg (t_slot, t_cell_cmd).
module scnfu_cell
    import scnfu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_shift,
    input  t_slot     i_d,
    input  t_cell_cmd i_cmd,
    output t_slot     o_q
);

    t_slot r_q;
    t_slot n_q;

    // Apply the update to the incoming slot
    always_comb begin
        n_q = i_d;
        if (i_cmd.clr_dirty) n_q.dirty = 1'b0;
        if (i_cmd.wr_dirty)  n_q.dirty = i_cmd.dirty_val;
        if (i_cmd.decay && (n_q.cnt != '0)) n_q.cnt = n_q.cnt - 1'b1;
        if (i_cmd.bump && n_q.used && n_q.accessed) begin
            if (n_q.cnt != COUNT_MAX) n_q.cnt = n_q.cnt + 1'b1;
            n_q.accessed = 1'b0;
        end
        if (i_cmd.set_acc) n_q.accessed = 1'b1;
        if (i_cmd.install) begin
            n_q.tag      = i_cmd.tag;
            n_q.used     = 1'b1;
            n_q.dirty    = 1'b0;
            n_q.accessed = 1'b1;
            n_q.cnt      = '0;
        end
    end

    // Advance the ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

### design/scnfu_rem.sv
// Bit-serial remainder unit: event counter modulo refresh limit, one bit a cycle.
// Depends on scnfu_pkg for widths.
module scnfu_rem
    import scnfu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CTR_W-1:0] i_dividend,
    input  logic [LIM_W-1:0] i_divisor,
    output logic             o_done,
    output logic             o_zero
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CTR_W-1:0]     r_dvd;
    logic [LIM_W-1:0]     r_dvs;
    logic [LIM_W-1:0]     r_rem;
    logic [LIM_W:0]       w_tmp;
    logic [LIM_W-1:0]     n_rem;

    // Shift in one dividend bit and subtract when it fits
    always_comb begin
        w_tmp = {r_rem, r_dvd[CTR_W-1]};
        if (w_tmp >= {1'b0, r_dvs}) begin
            n_rem = LIM_W'(w_tmp - {1'b0, r_dvs});
        end else begin
            n_rem = w_tmp[LIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(CTR_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[CTR_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_zero = (r_rem == '0);

endmodule

### design/sector_cache_nfu_replacement.sv
// Sector cache tag and NFU replacement controller: sequencer, ring of slot cells,
// remainder unit. Depends on scnfu_pkg, scnfu_if, scnfu_cell, scnfu_rem.
//
// The slots live in a ring of SLOTS cells that rotates one slot per cycle past a
// single head position, where all reads and updates take place; the ring holds
// still outside the maintenance, search and apply passes and while a writeback
// waits for the result register. One transaction is handled at a time. An access
// runs the refresh-limit remainder, one maintenance pass when an aging event is
// due, a search pass, a pick step, an apply pass and a response step. Set dirty
// and query run a search pass, a pick step, an apply pass when a tag matches and
// a response step; flush runs a maintenance pass and a response step. A result
// register still held by the sink stalls a writeback or the response. The input
// accepts a new transaction only once the final result of the previous one is registered.
module sector_cache_nfu_replacement
    import scnfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    scnfu_in_if.sink    i_in,
    scnfu_cfg_if.sink   i_cfg,
    scnfu_out_if.source o_out
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_DIV, PH_MAINT, PH_SEARCH, PH_PICK, PH_APPLY, PH_RESP
    } t_phase;

    t_phase r_phase;

    t_op                r_op;
    logic [TAG_W-1:0]   r_blk;
    logic               r_dval;
    logic [IDX_W-1:0]   r_start_mod;
    logic [CTR_W-1:0]   r_ctr;
    logic [LIM_W-1:0]   r_lim;
    logic [MUL_W-1:0]   r_mult;
    logic [CTR_W-1:0]   r_prod;
    logic [IDX_W-1:0]   r_pos;
    logic               r_flush;
    logic               r_age;
    logic               r_decay;
    logic               r_found;
    logic [IDX_W-1:0]   r_tgt;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic [COUNT_W-1:0] r_min;
    logic [IDX_W-1:0]   r_min_idx;
    logic [COUNT_W-1:0] r_start_cnt;
    logic               r_evict;
    logic               r_hit;
    logic               r_rd_dirty;
    logic               r_rd_used;
    logic [IDX_W-1:0]   r_resp_slot;
    logic               r_out_valid;
    t_result            r_out;

    t_slot      w_q [SLOTS];
    t_slot      w_head;
    t_cell_cmd  w_cmd;
    logic       w_emit_wb;
    logic       w_step;
    logic       w_can_load;
    logic       w_at_tgt;
    logic       w_last_pos;
    logic       w_match;
    logic       w_accept;
    logic       w_load_wb;
    logic       w_load_final;
    logic [LIM_W-1:0] w_lim_eff;
    logic [CTR_W-1:0] w_ctr_inc;
    logic             w_div_done;
    logic             w_div_zero;

    assign w_head     = w_q[0];
    assign w_can_load = !r_out_valid || o_out.ready;
    assign w_at_tgt   = (r_pos == r_tgt);
    assign w_last_pos = (r_pos == IDX_W'(SLOTS - 1));
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_lim_eff  = (r_lim == '0) ? LIM_W'(1) : r_lim;
    assign w_ctr_inc  = r_ctr + 1'b1;
    assign w_match    = (w_head.tag == r_blk) && ((r_op != OP_ACCESS) || w_head.used);
    assign w_load_wb    = w_emit_wb && w_step;
    assign w_load_final = (r_phase == PH_RESP) && w_can_load;

    assign i_in.ready  = (r_phase == PH_IDLE);
    assign i_cfg.ready = 1'b1;

    // Ring of slot cells; the tail takes the head slot with its update
    for (genvar k = 0; k < SLOTS; k++) begin : g_ring
        if (k == SLOTS - 1) begin : g_tail
            scnfu_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_step),
                .i_d     (w_q[0]),
                .i_cmd   (w_cmd),
                .o_q     (w_q[k])
            );
        end else begin : g_body
            scnfu_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_step),
                .i_d     (w_q[k+1]),
                .i_cmd   ('0),
                .o_q     (w_q[k])
            );
        end
    end

    scnfu_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && (t_op'(i_in.op) == OP_ACCESS)),
        .i_dividend (w_ctr_inc),
        .i_divisor  (w_lim_eff),
        .o_done     (w_div_done),
        .o_zero     (w_div_zero)
    );

    // Head update, writeback emission and ring advance
    always_comb begin
        w_cmd     = '0;
        w_cmd.tag = r_blk;
        w_cmd.dirty_val = r_dval;
        w_emit_wb = 1'b0;
        w_step    = 1'b0;
        unique case (r_phase)
            PH_MAINT: begin
                w_cmd.clr_dirty = r_flush;
                w_cmd.decay     = r_decay;
                w_cmd.bump      = r_age;
                w_emit_wb       = r_flush && w_head.dirty;
                w_step          = !w_emit_wb || w_can_load;
            end
            PH_SEARCH: begin
                w_step = 1'b1;
            end
            PH_APPLY: begin
                if (w_at_tgt) begin
                    unique case (r_op)
                        OP_ACCESS: begin
                            w_cmd.set_acc = r_hit;
                            w_cmd.install = !r_hit;
                            w_emit_wb     = !r_hit && r_evict && w_head.dirty;
                        end
                        OP_SET_DIRTY: w_cmd.wr_dirty = 1'b1;
                        OP_QUERY:     w_cmd.wr_dirty = 1'b0;
                        OP_FLUSH:     w_cmd.wr_dirty = 1'b0;
                        default:      w_cmd.wr_dirty = 1'b0;
                    endcase
                end
                w_step = !w_emit_wb || w_can_load;
            end
            default: begin
                w_step = 1'b0;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim  <= LIM_W'(64);
            r_mult <= MUL_W'(4);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_REFRESH_LIMIT: r_lim  <= i_cfg.data[LIM_W-1:0];
                CFG_DELAY_MULT:    r_mult <= i_cfg.data[MUL_W-1:0];
                default:           r_lim  <= r_lim;
            endcase
        end
    end

    // Sequencer, search bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ctr       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_wb || w_load_final) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load_wb) begin
                r_out.kind        <= KIND_WRITEBACK;
                r_out.slot        <= SLOT_W'(r_pos);
                r_out.sector      <= w_head.tag;
                r_out.hit         <= 1'b0;
                r_out.dirty_flag  <= 1'b0;
                r_out.used_flag   <= 1'b0;
                r_out.last        <= 1'b0;
            end
            if (w_step) begin
                r_pos <= w_last_pos ? '0 : r_pos + 1'b1;
            end

            unique case (r_phase)
                PH_IDLE: begin
                    if (w_accept) begin
                        r_op         <= t_op'(i_in.op);
                        r_blk        <= i_in.sector_id;
                        r_dval       <= i_in.dirty_value;
                        r_start_mod  <= IDX_W'(32'(i_in.start_slot) % SLOTS);
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_hit        <= 1'b0;
                        r_evict      <= 1'b0;
                        r_rd_dirty   <= 1'b0;
                        r_rd_used    <= 1'b0;
                        r_resp_slot  <= '0;
                        r_prod       <= {{(CTR_W-LIM_W){1'b0}}, w_lim_eff}
                                        * {{(CTR_W-MUL_W){1'b0}}, r_mult};
                        r_flush      <= 1'b0;
                        r_age        <= 1'b0;
                        r_decay      <= 1'b0;
                        unique case (t_op'(i_in.op))
                            OP_ACCESS: begin
                                r_ctr   <= w_ctr_inc;
                                r_phase <= PH_DIV;
                            end
                            OP_FLUSH: begin
                                r_flush <= 1'b1;
                                r_phase <= PH_MAINT;
                            end
                            default: r_phase <= PH_SEARCH;
                        endcase
                    end
                end
                PH_DIV: begin
                    if (w_div_done) begin
                        if (w_div_zero) begin
                            r_age   <= 1'b1;
                            r_phase <= PH_MAINT;
                            if (r_ctr > r_prod) begin
                                r_flush <= 1'b1;
                                r_decay <= 1'b1;
                                r_ctr   <= '0;
                            end else begin
                                r_decay <= (r_ctr == '0);
                            end
                        end else begin
                            r_phase <= PH_SEARCH;
                        end
                    end
                end
                PH_MAINT: begin
                    if (w_step && w_last_pos) begin
                        r_phase <= (r_op == OP_FLUSH) ? PH_RESP : PH_SEARCH;
                    end
                end
                PH_SEARCH: begin
                    if (w_match && !r_found) begin
                        r_found <= 1'b1;
                        r_tgt   <= r_pos;
                    end
                    if (!w_head.used && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_pos;
                    end
                    if ((r_pos == '0) || (w_head.cnt < r_min)) begin
                        r_min     <= w_head.cnt;
                        r_min_idx <= r_pos;
                    end
                    if (r_pos == r_start_mod) r_start_cnt <= w_head.cnt;
                    if (w_last_pos) r_phase <= PH_PICK;
                end
                PH_PICK: begin
                    if (r_found) begin
                        r_hit   <= 1'b1;
                        r_phase <= PH_APPLY;
                    end else if (r_op == OP_ACCESS) begin
                        r_evict <= !r_free_found;
                        if (r_free_found) begin
                            r_tgt <= r_free_idx;
                        end else if (r_start_cnt == r_min) begin
                            r_tgt <= r_start_mod;
                        end else begin
                            r_tgt <= r_min_idx;
                        end
                        r_phase <= PH_APPLY;
                    end else begin
                        r_phase <= PH_RESP;
                    end
                end
                PH_APPLY: begin
                    if (w_at_tgt) begin
                        r_resp_slot <= r_pos;
                        if (r_op == OP_QUERY) begin
                            r_rd_dirty <= w_head.dirty;
                            r_rd_used  <= w_head.used;
                        end
                    end
                    if (w_step && w_last_pos) r_phase <= PH_RESP;
                end
                PH_RESP: begin
                    if (w_can_load) begin
                        r_out.kind       <= KIND_FINAL;
                        r_out.slot       <= SLOT_W'(r_resp_slot);
                        r_out.sector     <= r_blk;
                        r_out.hit        <= r_hit;
                        r_out.dirty_flag <= r_rd_dirty;
                        r_out.used_flag  <= r_rd_used;
                        r_out.last       <= 1'b1;
                        r_phase          <= PH_IDLE;
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out.kind;
    assign o_out.slot       = r_out.slot;
    assign o_out.sector     = r_out.sector;
    assign o_out.hit        = r_out.hit;
    assign o_out.dirty_flag = r_out.dirty_flag;
    assign o_out.used_flag  = r_out.used_flag;
    assign o_out.last       = r_out.last;

endmodule
